[rtl/core/rcam_pkg.sv]
// Package for the range count core: field widths, operation codes and the
// controller state type. No dependencies.
package rcam_pkg;

    localparam int VAL_W      = 32;
    localparam int FIRST_W    = 10;
    localparam int END_W      = 11;
    localparam int CNT_W      = 11;
    localparam int S_TDATA_W  = 56;
    localparam int M_TDATA_W  = 16;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_COUNT = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_W_DIV,
        ST_W_SET,
        ST_W_RUN,
        ST_W_TAIL,
        ST_C_DIV,
        ST_C_SET,
        ST_C_SCAN,
        ST_C_BS_RD,
        ST_C_BS_CMP,
        ST_DONE
    } state_t;

endpackage

[rtl/core/range_count_at_most_core.sv]
// Top level of the range count core: controller over the value table and the
// per-block sorted copies. Depends on rcam_pkg, rcam_ram and rcam_div.
//
//  channel | direction | fields
//  s_      | in        | tuser: operation; tdata: first_index, end_index, value
//  m_      | out       | tdata: count_result
//
// After reset the core clears both memories before the first request.
// A write looks up its block through the divider, writes the new value and then
// streams the sorted block through the memory port.
// A count looks up its edge blocks through the divider, scans the edge entries and
// binary-searches each whole block between them, all set by the single read port
// of each memory.
// One request is worked at a time; a finished count waits in the output register.
module range_count_at_most_core #(
    parameter int ENTRIES    = 1024,
    parameter int BLOCK_SIZE = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [rcam_pkg::S_TDATA_W-1:0]    s_tdata,  // first_index, end_index, value
    input  logic                              s_tuser,  // operation
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [rcam_pkg::M_TDATA_W-1:0]    m_tdata   // count_result
);
    import rcam_pkg::*;

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int PW = $clog2(ENTRIES + 1);
    localparam int EW = (PW > END_W) ? PW : END_W;
    localparam int BW = $clog2(BLOCK_SIZE + 1);
    localparam logic [EW-1:0] ENT_E = EW'(ENTRIES);
    localparam logic [EW-1:0] BS_E  = EW'(BLOCK_SIZE);
    localparam logic [BW-1:0] BS_B  = BW'(BLOCK_SIZE);
    localparam logic [AW-1:0] LAST_A = AW'(ENTRIES - 1);

    state_t state_reg, state_next;

    logic [EW-1:0] f_reg, f_next, e_reg, e_next;
    logic signed [VAL_W-1:0] x_reg, x_next, old_reg, old_next, hold_reg, hold_next;
    logic [EW-1:0] lo_reg, lo_next;
    logic [BW-1:0] n_reg, n_next, r_reg, r_next, w_reg, w_next;
    logic pend_reg, pend_next, held_reg, held_next, ins_reg, ins_next;
    logic rmv_reg, rmv_next, right_reg, right_next;
    logic [EW-1:0] kl_reg, kl_next, kr_reg, kr_next, ptr_reg, ptr_next;
    logic [EW-1:0] stop_reg, stop_next, base_reg, base_next, blk_reg, blk_next;
    logic [BW-1:0] a_reg, a_next, b_reg, b_next, mid_reg, mid_next;
    logic [EW-1:0] acc_reg, acc_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic m_tvalid_reg, m_tvalid_next;
    logic [CNT_W-1:0] cnt_out_reg, cnt_out_next;

    logic [EW-1:0] in_first, in_end_raw, in_end, ent_left;
    logic [BW:0]   ab_sum;
    logic [BW-1:0] mid;
    logic          div_start, div_done, div_a_done, div_b_done;
    logic [EW-1:0] div_a_in, div_b_in, div_a_q, div_b_q;

    logic                    vwe, swe;
    logic [AW-1:0]           vwaddr, vraddr, swaddr, sraddr;
    logic signed [VAL_W-1:0] vwdata, vrdata, swdata, srdata;
    logic                    skip, emitv;

    assign in_first   = EW'(s_tdata[FIRST_W-1:0]);
    assign in_end_raw = EW'(s_tdata[FIRST_W+END_W-1:FIRST_W]);
    assign in_end     = (in_end_raw > ENT_E) ? ENT_E : in_end_raw;
    assign ab_sum     = {1'b0, a_reg} + {1'b0, b_reg};
    assign mid        = ab_sum[BW:1];
    assign ent_left   = ENT_E - lo_reg;
    assign skip       = !rmv_reg && (srdata == old_reg);
    assign emitv      = !ins_reg && (srdata > x_reg);
    assign div_done   = div_a_done && div_b_done;

    rcam_ram #(.DEPTH(ENTRIES), .AW(AW)) u_values (
        .clk(clk), .we(vwe), .waddr(vwaddr), .wdata(vwdata),
        .raddr(vraddr), .rdata(vrdata)
    );

    rcam_ram #(.DEPTH(ENTRIES), .AW(AW)) u_sorted (
        .clk(clk), .we(swe), .waddr(swaddr), .wdata(swdata),
        .raddr(sraddr), .rdata(srdata)
    );

    rcam_div #(.WIDTH(EW), .DIVISOR(BLOCK_SIZE)) u_div_a (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_a_in),
        .quotient(div_a_q), .done(div_a_done)
    );

    rcam_div #(.WIDTH(EW), .DIVISOR(BLOCK_SIZE)) u_div_b (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_b_in),
        .quotient(div_b_q), .done(div_b_done)
    );

    always_comb
    begin
        state_next    = state_reg;
        f_next        = f_reg;
        e_next        = e_reg;
        x_next        = x_reg;
        old_next      = old_reg;
        hold_next     = hold_reg;
        lo_next       = lo_reg;
        n_next        = n_reg;
        r_next        = r_reg;
        w_next        = w_reg;
        pend_next     = pend_reg;
        held_next     = held_reg;
        ins_next      = ins_reg;
        rmv_next      = rmv_reg;
        right_next    = right_reg;
        kl_next       = kl_reg;
        kr_next       = kr_reg;
        ptr_next      = ptr_reg;
        stop_next     = stop_reg;
        base_next     = base_reg;
        blk_next      = blk_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        mid_next      = mid_reg;
        acc_next      = acc_reg;
        clr_next      = clr_reg;
        m_tvalid_next = m_tvalid_reg;
        cnt_out_next  = cnt_out_reg;
        s_tready      = 1'b0;
        div_start     = 1'b0;
        div_a_in      = in_first;
        div_b_in      = in_end - 1'b1;
        vwe           = 1'b0;
        vwaddr        = clr_reg;
        vwdata        = '0;
        vraddr        = f_reg[AW-1:0];
        swe           = 1'b0;
        swaddr        = clr_reg;
        swdata        = '0;
        sraddr        = AW'(base_reg + EW'(mid));

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                vwe = 1'b1;
                swe = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == LAST_A)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    f_next = in_first;
                    e_next = in_end;
                    x_next = s_tdata[FIRST_W+END_W+VAL_W-1:FIRST_W+END_W];
                    if (s_tuser == OP_WRITE)
                    begin
                        if (in_first < ENT_E)
                        begin
                            div_start  = 1'b1;
                            state_next = ST_W_DIV;
                        end
                    end
                    else if (in_first >= in_end)
                    begin
                        acc_next   = '0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = ST_C_DIV;
                    end
                end
            end
            ST_W_DIV:
            begin
                if (div_done)
                begin
                    old_next   = vrdata;
                    lo_next    = EW'(div_a_q * BS_E);
                    state_next = ST_W_SET;
                end
            end
            ST_W_SET:
            begin
                vwe        = 1'b1;
                vwaddr     = f_reg[AW-1:0];
                vwdata     = x_reg;
                n_next     = (ent_left < BS_E) ? BW'(ent_left) : BS_B;
                r_next     = '0;
                w_next     = '0;
                pend_next  = 1'b0;
                held_next  = 1'b0;
                ins_next   = 1'b0;
                rmv_next   = 1'b0;
                state_next = ST_W_RUN;
            end
            ST_W_RUN:
            begin
                sraddr = AW'(lo_reg + EW'(r_reg));
                if (r_reg < n_reg)
                begin
                    r_next    = r_reg + 1'b1;
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
                swaddr = AW'(lo_reg + EW'(w_reg));
                if (pend_reg)
                begin
                    ins_next  = ins_reg | emitv;
                    rmv_next  = rmv_reg | skip;
                    held_next = 1'b0;
                    if (held_reg)
                    begin
                        swe       = 1'b1;
                        swdata    = hold_reg;
                        held_next = !skip;
                        hold_next = srdata;
                    end
                    else if (emitv)
                    begin
                        swe       = 1'b1;
                        swdata    = x_reg;
                        held_next = !skip;
                        hold_next = srdata;
                    end
                    else if (!skip)
                    begin
                        swe    = 1'b1;
                        swdata = srdata;
                    end
                    if (swe)
                    begin
                        w_next = w_reg + 1'b1;
                    end
                end
                else if (!(r_reg < n_reg))
                begin
                    state_next = ST_W_TAIL;
                end
            end
            ST_W_TAIL:
            begin
                swaddr     = AW'(lo_reg + EW'(w_reg));
                swe        = held_reg || !ins_reg;
                swdata     = held_reg ? hold_reg : x_reg;
                state_next = ST_IDLE;
            end
            ST_C_DIV:
            begin
                if (div_done)
                begin
                    kl_next    = div_a_q;
                    kr_next    = div_b_q;
                    state_next = ST_C_SET;
                end
            end
            ST_C_SET:
            begin
                ptr_next   = f_reg;
                stop_next  = (kl_reg == kr_reg) ? e_reg : EW'((kl_reg + 1'b1) * BS_E);
                blk_next   = kl_reg + 1'b1;
                base_next  = EW'((kl_reg + 1'b1) * BS_E);
                right_next = 1'b0;
                pend_next  = 1'b0;
                acc_next   = '0;
                state_next = ST_C_SCAN;
            end
            ST_C_SCAN:
            begin
                vraddr = ptr_reg[AW-1:0];
                if (ptr_reg < stop_reg)
                begin
                    ptr_next  = ptr_reg + 1'b1;
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg)
                begin
                    if (vrdata <= x_reg)
                    begin
                        acc_next = acc_reg + 1'b1;
                    end
                end
                else if (!(ptr_reg < stop_reg))
                begin
                    if (right_reg || (kl_reg == kr_reg))
                    begin
                        state_next = ST_DONE;
                    end
                    else if (blk_reg < kr_reg)
                    begin
                        a_next     = '0;
                        b_next     = BS_B;
                        state_next = ST_C_BS_RD;
                    end
                    else
                    begin
                        ptr_next   = base_reg;
                        stop_next  = e_reg;
                        right_next = 1'b1;
                    end
                end
            end
            ST_C_BS_RD:
            begin
                if (a_reg < b_reg)
                begin
                    mid_next   = mid;
                    state_next = ST_C_BS_CMP;
                end
                else
                begin
                    acc_next = acc_reg + EW'(a_reg);
                    if ((blk_reg + 1'b1) < kr_reg)
                    begin
                        blk_next  = blk_reg + 1'b1;
                        base_next = base_reg + BS_E;
                        a_next    = '0;
                        b_next    = BS_B;
                    end
                    else
                    begin
                        ptr_next   = base_reg + BS_E;
                        stop_next  = e_reg;
                        right_next = 1'b1;
                        pend_next  = 1'b0;
                        state_next = ST_C_SCAN;
                    end
                end
            end
            ST_C_BS_CMP:
            begin
                if (srdata <= x_reg)
                begin
                    a_next = mid_reg + 1'b1;
                end
                else
                begin
                    b_next = mid_reg;
                end
                state_next = ST_C_BS_RD;
            end
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    cnt_out_next  = acc_reg[CNT_W-1:0];
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            pend_reg     <= 1'b0;
            held_reg     <= 1'b0;
            ins_reg      <= 1'b0;
            rmv_reg      <= 1'b0;
            right_reg    <= 1'b0;
            r_reg        <= '0;
            w_reg        <= '0;
            n_reg        <= '0;
            a_reg        <= '0;
            b_reg        <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            m_tvalid_reg <= m_tvalid_next;
            pend_reg     <= pend_next;
            held_reg     <= held_next;
            ins_reg      <= ins_next;
            rmv_reg      <= rmv_next;
            right_reg    <= right_next;
            r_reg        <= r_next;
            w_reg        <= w_next;
            n_reg        <= n_next;
            a_reg        <= a_next;
            b_reg        <= b_next;
        end
    end

    always_ff @(posedge clk)
    begin
        f_reg       <= f_next;
        e_reg       <= e_next;
        x_reg       <= x_next;
        old_reg     <= old_next;
        hold_reg    <= hold_next;
        lo_reg      <= lo_next;
        kl_reg      <= kl_next;
        kr_reg      <= kr_next;
        ptr_reg     <= ptr_next;
        stop_reg    <= stop_next;
        base_reg    <= base_next;
        blk_reg     <= blk_next;
        mid_reg     <= mid_next;
        acc_reg     <= acc_next;
        cnt_out_reg <= cnt_out_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'(cnt_out_reg);

    // The sorted block is never written ahead of the entry being read.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_W_RUN) |-> (w_reg <= r_reg))
        else $error("sorted block write index passed read index");

    // The binary search window never inverts.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_C_BS_RD || state_reg == ST_C_BS_CMP) |-> (a_reg <= b_reg))
        else $error("binary search bounds crossed");

    // No request is taken while the memories are being cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !s_tready && !m_tvalid)
        else $error("request handshake during memory clear");

    // A count never exceeds the table size.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |-> (acc_reg <= ENT_E))
        else $error("count larger than table");

endmodule

[rtl/core/rcam_ram.sv]
// Single-port-write, single-port-read synchronous RAM of signed 32-bit words.
// Depends on rcam_pkg for the word width.
module rcam_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                               clk,
    input  logic                               we,
    input  logic [AW-1:0]                      waddr,
    input  logic signed [rcam_pkg::VAL_W-1:0]  wdata,
    input  logic [AW-1:0]                      raddr,
    output logic signed [rcam_pkg::VAL_W-1:0]  rdata
);
    import rcam_pkg::*;

    logic signed [VAL_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

[rtl/core/rcam_div.sv]
// Division by a fixed divisor through multiplication with its scaled reciprocal.
// done trails start via busy_reg, done_reg. Depends on nothing but its parameters.
module rcam_div #(
    parameter int WIDTH   = 11,
    parameter int DIVISOR = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [WIDTH-1:0] dividend,
    output logic [WIDTH-1:0] quotient,
    output logic             done
);
    localparam int SH = WIDTH + $clog2(DIVISOR);
    localparam int MW = SH + 1;
    localparam longint RECIP_L =
        ((longint'(1) << SH) + longint'(DIVISOR) - 1) / longint'(DIVISOR);
    localparam logic [MW-1:0] RECIP = MW'(RECIP_L);

    logic [WIDTH+MW-1:0] prod;
    logic [WIDTH-1:0]    quo_reg, quo_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;

    assign prod = {{MW{1'b0}}, dividend} * {{WIDTH{1'b0}}, RECIP};

    always_comb
    begin
        quo_next  = quo_reg;
        busy_next = start;
        done_next = busy_reg;
        if (start)
        begin
            quo_next = prod[SH +: WIDTH];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quo_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            quo_reg  <= quo_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule
